[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define SMI_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[hw/rtl/smi_pkg.sv]
// Shared types and constants of the small matrix inverse block.
package smi_pkg;

  localparam int ENT_W = 32;
  localparam int DET_W = 48;
  localparam int N_ENT = 9;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_SINGULAR = 2'd1;
  localparam status_t ST_SAT      = 2'd2;

endpackage

[hw/rtl/small_matrix_inverse.sv]
// Small matrix inverse: determinant and inverse of a 1x1, 2x2 or 3x3 fixed-point matrix.
//
// Each input word carries one square matrix of order in_size (1 to 3) with signed entries
// holding FRAC_BITS fraction bits; entries outside the used order are ignored. The block
// returns the determinant with FRAC_BITS fraction bits in 48 bits and the inverse in the
// entry format. Order 1 gives the reciprocal, order 2 the swapped and negated form over the
// determinant, and order 3 the adjugate over the determinant. Products and the determinant
// are exact; every result is rounded once, to nearest with halves away from zero. A zero
// determinant reports singular status with all results zero, and a result outside its field
// is clamped with saturated status. Order 0 returns a determinant of 1.0 and a zero inverse.
// Unused inverse entries are zero. The block takes one word per cycle through a pipeline of
// 41 register stages, and out_valid rises for a word once it has passed through all of
// them: one multiply stage, six stages that form the cofactors, the determinant and the
// divider operands, one overflow compare, 32 stages of a restoring divider that retires one
// quotient bit per stage for all nine entries in parallel, and the output register. The
// whole pipeline holds while a result waits on out_stall, so no word is lost or repeated;
// empty stages hold as well, so gaps in the input stream keep their place.
module small_matrix_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_size,
  input  logic signed [31:0]  in_m00,
  input  logic signed [31:0]  in_m01,
  input  logic signed [31:0]  in_m02,
  input  logic signed [31:0]  in_m10,
  input  logic signed [31:0]  in_m11,
  input  logic signed [31:0]  in_m12,
  input  logic signed [31:0]  in_m20,
  input  logic signed [31:0]  in_m21,
  input  logic signed [31:0]  in_m22,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_inv00,
  output logic signed [31:0]  out_inv01,
  output logic signed [31:0]  out_inv02,
  output logic signed [31:0]  out_inv10,
  output logic signed [31:0]  out_inv11,
  output logic signed [31:0]  out_inv12,
  output logic signed [31:0]  out_inv20,
  output logic signed [31:0]  out_inv21,
  output logic signed [31:0]  out_inv22,
  output logic signed [47:0]  out_determinant,
  output logic [1:0]          out_status
);

  // Widths of the divider datapath. The numerator is the cofactor magnitude shifted left by
  // 2*FRAC_BITS+1 plus the determinant magnitude; the divisor is twice that magnitude.
  localparam int NSH = 2 * FRAC_BITS + 1;
  localparam int NW  = (2 * FRAC_BITS + 66 > 98) ? 2 * FRAC_BITS + 66 : 98;
  localparam int XW  = NW + 32;
  localparam int QB  = 32;

  // Operand indexes of the cofactor products: num = a[PA]*a[PB] - a[MA]*a[MB].
  localparam logic [3:0] PA [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] PB [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] MA [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] MB [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // Per-word information that rides along the divider stages.
  typedef struct packed {
    logic [smi_pkg::N_ENT-1:0]     ineg;
    logic [smi_pkg::N_ENT-1:0]     ovf;
    logic                          zero;
    logic [1:0]                    size;
    logic signed [smi_pkg::DET_W-1:0] det;
    logic                          dsat;
  } side_t;

  logic en;
  logic signed [31:0] a_in [9];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign a_in[0] = in_m00;
  assign a_in[1] = in_m01;
  assign a_in[2] = in_m02;
  assign a_in[3] = in_m10;
  assign a_in[4] = in_m11;
  assign a_in[5] = in_m12;
  assign a_in[6] = in_m20;
  assign a_in[7] = in_m21;
  assign a_in[8] = in_m22;

  // Stage 1: all eighteen 32x32 products.
  logic               v1_r;
  logic [1:0]         size1_r;
  logic signed [31:0] a1_r [9];
  logic signed [63:0] pp1_r [9];
  logic signed [63:0] pm1_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size1_r <= in_size;
      for (int i = 0; i < 9; i++) begin
        a1_r[i]  <= a_in[i];
        pp1_r[i] <= a_in[PA[i]] * a_in[PB[i]];
        pm1_r[i] <= a_in[MA[i]] * a_in[MB[i]];
      end
    end
  end

  // Stage 2: cofactor differences and the numerators for the order in use.
  logic               v2_r;
  logic [1:0]         size2_r;
  logic signed [31:0] a2_r [3];
  logic signed [63:0] num2_r [9];
  logic signed [64:0] det2_r;
  logic signed [64:0] diff [9];
  logic signed [63:0] num_nxt [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      diff[i]    = {pp1_r[i][63], pp1_r[i]} - {pm1_r[i][63], pm1_r[i]};
      num_nxt[i] = 64'sd0;
    end
    case (size1_r)
      2'd1: begin
        num_nxt[0] = 64'sd1;
      end
      2'd2: begin
        num_nxt[0] = {{32{a1_r[4][31]}}, a1_r[4]};
        num_nxt[1] = -{{32{a1_r[1][31]}}, a1_r[1]};
        num_nxt[3] = -{{32{a1_r[3][31]}}, a1_r[3]};
        num_nxt[4] = {{32{a1_r[0][31]}}, a1_r[0]};
      end
      2'd3: begin
        for (int i = 0; i < 9; i++) begin
          num_nxt[i] = diff[i][63:0];
        end
      end
      default: begin
        num_nxt[0] = 64'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size2_r <= size1_r;
      det2_r  <= diff[8];
      for (int i = 0; i < 3; i++) begin
        a2_r[i] <= a1_r[i];
      end
      for (int i = 0; i < 9; i++) begin
        num2_r[i] <= num_nxt[i];
      end
    end
  end

  // Stage 3: first-row entries times the cofactors, split into 32-bit halves.
  logic               v3_r;
  logic [1:0]         size3_r;
  logic signed [31:0] a0_3_r;
  logic signed [64:0] det2_3_r;
  logic signed [63:0] num3_r [9];
  logic signed [64:0] pl3_r [3];
  logic signed [63:0] ph3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size3_r  <= size2_r;
      a0_3_r   <= a2_r[0];
      det2_3_r <= det2_r;
      for (int i = 0; i < 9; i++) begin
        num3_r[i] <= num2_r[i];
      end
      for (int t = 0; t < 3; t++) begin
        pl3_r[t] <= a2_r[t] * $signed({1'b0, num2_r[3*t][31:0]});
        ph3_r[t] <= a2_r[t] * $signed(num2_r[3*t][63:32]);
      end
    end
  end

  // Stage 4: recombine the halves into full products.
  logic               v4_r;
  logic [1:0]         size4_r;
  logic signed [31:0] a0_4_r;
  logic signed [64:0] det2_4_r;
  logic signed [63:0] num4_r [9];
  logic signed [96:0] pr4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size4_r  <= size3_r;
      a0_4_r   <= a0_3_r;
      det2_4_r <= det2_3_r;
      for (int i = 0; i < 9; i++) begin
        num4_r[i] <= num3_r[i];
      end
      for (int t = 0; t < 3; t++) begin
        pr4_r[t] <= {ph3_r[t][63], ph3_r[t], 32'd0} + {{32{pl3_r[t][64]}}, pl3_r[t]};
      end
    end
  end

  // Stage 5: exact determinant for the order in use.
  logic               v5_r;
  logic [1:0]         size5_r;
  logic signed [63:0] num5_r [9];
  logic signed [96:0] det5_r;
  logic signed [96:0] det_nxt;

  always_comb begin
    case (size4_r)
      2'd1:    det_nxt = {{65{a0_4_r[31]}}, a0_4_r};
      2'd2:    det_nxt = {{32{det2_4_r[64]}}, det2_4_r};
      2'd3:    det_nxt = pr4_r[0] + pr4_r[1] + pr4_r[2];
      default: det_nxt = 97'sd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size5_r <= size4_r;
      det5_r  <= det_nxt;
      for (int i = 0; i < 9; i++) begin
        num5_r[i] <= num4_r[i];
      end
    end
  end

  // Stage 6: signs and magnitudes.
  logic        v6_r;
  logic [1:0]  size6_r;
  logic        dneg6_r;
  logic        zero6_r;
  logic [95:0] mag6_r;
  logic [63:0] nmag6_r [9];
  logic [8:0]  ineg6_r;
  logic [96:0] det_abs;

  assign det_abs = det5_r[96] ? 97'(-det5_r) : 97'(det5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size6_r <= size5_r;
      dneg6_r <= det5_r[96];
      zero6_r <= (det5_r == 97'sd0);
      mag6_r  <= det_abs[95:0];
      for (int i = 0; i < 9; i++) begin
        nmag6_r[i] <= num5_r[i][63] ? 64'(-num5_r[i]) : 64'(num5_r[i]);
        ineg6_r[i] <= num5_r[i][63] ^ det5_r[96];
      end
    end
  end

  // Stage 7: determinant rounding and packing, divider operands.
  logic          v7_r;
  side_t         side7_r;
  logic [XW-1:0] n7_r [9];
  logic [XW-1:0] d7_r;
  logic [96:0]   drnd;
  logic [96:0]   dlim;
  logic          dsat;
  logic [47:0]   dmag;

  always_comb begin
    case (size6_r)
      2'd2:    drnd = ({1'b0, mag6_r} + (97'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      2'd3:    drnd = ({1'b0, mag6_r} + (97'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      default: drnd = {1'b0, mag6_r};
    endcase
    dlim = dneg6_r ? (97'd1 << (smi_pkg::DET_W - 1)) : ((97'd1 << (smi_pkg::DET_W - 1)) - 97'd1);
    dsat = (drnd > dlim);
    dmag = dsat ? dlim[47:0] : drnd[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side7_r.ineg <= ineg6_r;
      side7_r.ovf  <= '0;
      side7_r.zero <= zero6_r;
      side7_r.size <= size6_r;
      side7_r.det  <= dneg6_r ? $signed(-dmag) : $signed(dmag);
      side7_r.dsat <= dsat;
      d7_r         <= XW'(mag6_r) << 1;
      for (int i = 0; i < 9; i++) begin
        n7_r[i] <= (XW'(nmag6_r[i]) << NSH) + XW'(mag6_r);
      end
    end
  end

  // Divider: stage 0 checks for a quotient of 2^32 or more, stages 1..32 retire one
  // quotient bit each, most significant first.
  logic          vd_r   [QB+1];
  side_t         side_r [QB+1];
  logic [XW-1:0] rem_r  [QB+1][9];
  logic [QB-1:0] quo_r  [QB+1][9];
  logic [XW-1:0] dv_r   [QB+1];
  side_t         side0_nxt;

  always_comb begin
    side0_nxt = side7_r;
    for (int i = 0; i < 9; i++) begin
      side0_nxt.ovf[i] = (n7_r[i] >= (d7_r << QB));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]      <= side0_nxt;
      dv_r[0]        <= d7_r;
      for (int i = 0; i < 9; i++) begin
        rem_r[0][i]      <= n7_r[i];
        quo_r[0][i]      <= '0;
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    localparam int J = QB - k;
    logic [XW-1:0] dsh;

    assign dsh = dv_r[k-1] << J;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en) begin
        vd_r[k] <= vd_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
        dv_r[k]   <= dv_r[k-1];
        for (int i = 0; i < 9; i++) begin
          if (rem_r[k-1][i] >= dsh) begin
            rem_r[k][i]    <= rem_r[k-1][i] - dsh;
            quo_r[k][i]    <= quo_r[k-1][i] | (QB'(1) << J);
          end else begin
            rem_r[k][i]    <= rem_r[k-1][i];
            quo_r[k][i]    <= quo_r[k-1][i];
          end
        end
      end
    end
  end

  // Output register: saturate, apply signs and resolve the special cases.
  logic               out_valid_r;
  logic signed [31:0] inv_r [9];
  logic signed [47:0] det_r;
  smi_pkg::status_t   status_r;
  logic signed [31:0] inv_val [9];
  logic [8:0]         isat;
  side_t              sf;

  assign sf = side_r[QB];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      logic [31:0] q;
      logic [31:0] m;
      q       = quo_r[QB][i];
      isat[i] = sf.ovf[i] || (sf.ineg[i] ? (q[31] && (|q[30:0])) : q[31]);
      m       = isat[i] ? (sf.ineg[i] ? 32'h8000_0000 : 32'h7fff_ffff) : q;
      inv_val[i] = sf.ineg[i] ? $signed(-m) : $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sf.size == 2'd0) begin
        for (int i = 0; i < 9; i++) begin
          inv_r[i] <= 32'sd0;
        end
        det_r    <= 48'sd1 <<< FRAC_BITS;
        status_r <= smi_pkg::ST_OK;
      end else if (sf.zero) begin
        for (int i = 0; i < 9; i++) begin
          inv_r[i] <= 32'sd0;
        end
        det_r    <= 48'sd0;
        status_r <= smi_pkg::ST_SINGULAR;
      end else begin
        for (int i = 0; i < 9; i++) begin
          inv_r[i] <= inv_val[i];
        end
        det_r    <= sf.det;
        status_r <= ((|isat) || sf.dsat) ? smi_pkg::ST_SAT : smi_pkg::ST_OK;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inv00       = inv_r[0];
  assign out_inv01       = inv_r[1];
  assign out_inv02       = inv_r[2];
  assign out_inv10       = inv_r[3];
  assign out_inv11       = inv_r[4];
  assign out_inv12       = inv_r[5];
  assign out_inv20       = inv_r[6];
  assign out_inv21       = inv_r[7];
  assign out_inv22       = inv_r[8];
  assign out_determinant = det_r;
  assign out_status      = status_r;

endmodule

[hw/rtl/smi_checker.sv]
// Port-level checker for the small matrix inverse block and its bind.
`include "assert_macros.svh"

module smi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_inv00,
  input logic signed [47:0] out_determinant,
  input logic [1:0]         out_status
);

  logic sing_bad;

  assign sing_bad = out_valid && (out_status == smi_pkg::ST_SINGULAR) &&
                    (out_determinant != 48'sd0 || out_inv00 != 32'sd0);

  // A stalled result stays on offer.
  `SMI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // The input side holds exactly when a finished word waits on the output.
  `SMI_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "input stall not tied to output")

  // A singular result carries a zero determinant and a zero inverse.
  `SMI_ASSERT(a_singular_zero, !sing_bad, "singular result not cleared")

  // The input only holds while a result waits, and that result is still offered next cycle.
  `SMI_ASSERT_NEXT(a_in_hold, in_stall, out_valid, "input held without a waiting result")

endmodule

bind small_matrix_inverse smi_checker u_smi_checker (.*);
